>>> rtl/slpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpht_pkg: shared types and constants of the stamped hash table
// Commands, put actions, controller states, the result struct and the key
// helpers used by the front end and the probe controller.
// ----------------------------------------------------------------------------
package slpht_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_FOLD_CASE = 1'b0;   // register index from paddr[2]

  localparam logic [1:0] CMD_FIND  = 2'd0;
  localparam logic [1:0] CMD_PUT   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_INSERTED = 3'd1;
  localparam logic [2:0] ACT_REPLACED = 3'd2;
  localparam logic [2:0] ACT_KEPT     = 3'd3;
  localparam logic [2:0] ACT_FULL     = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PROBE,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        load_high;
    logic [2:0]  put_action;
    logic [31:0] found_node;
    logic        hit;
  } res_t;

  // String semantics: every byte from the first zero byte onward reads as zero
  function automatic logic [63:0] key_canon(input logic [63:0] w);
    logic [63:0] r;
    logic        live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (w[8*i +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*i +: 8] = w[8*i +: 8];
      end
    end
    return r;
  endfunction

  // Fold ASCII A-Z to a-z in every byte
  function automatic logic [63:0] key_fold(input logic [63:0] w);
    logic [63:0] r;
    logic [7:0]  b;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      b = w[8*i +: 8];
      if (b >= 8'h41 && b <= 8'h5A) begin
        b = b + 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

endpackage

>>> rtl/slpht_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpht_mem: slot memory
// Simple dual-port synchronous RAM, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module slpht_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 161
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/slpht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpht_ctrl: probe controller
// Holds the item, walks the slot memory one slot a cycle, writes back on a
// put, sweeps the valid marks on reset and on clear, and keeps the entry count.
// ----------------------------------------------------------------------------
module slpht_ctrl #(
  parameter int unsigned SLOTS    = 1024,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  ready,
  input  logic [1:0]            cmd,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [31:0]           hash,
  input  logic [31:0]           node,
  input  logic [31:0]           stamp,
  input  logic                  fold_case,
  input  logic                  res_free,
  output logic                  res_valid,
  output slpht_pkg::res_t       res
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = 1 + 32 + 32 + 32 + KEY_BITS;
  localparam logic [CW-1:0] LOAD_LIM = CW'((3 * SLOTS) / 4);

  slpht_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       nvis_r, nvis_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [31:0]         hash_r, hash_nxt;
  logic [31:0]         node_r, node_nxt;
  logic [31:0]         stamp_r, stamp_nxt;
  slpht_pkg::res_t     res_r, res_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  logic                ent_valid;
  logic [31:0]         ent_hash;
  logic [31:0]         ent_stamp;
  logic [31:0]         ent_node;
  logic [KEY_BITS-1:0] ent_key;
  logic                key_eq;
  logic                match;
  logic                empty;
  logic                last;
  logic [EW-1:0]       item_entry;

  slpht_mem #(
    .DEPTH(SLOTS),
    .WIDTH(EW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Entry layout from the top: valid, hash, stamp, node, key
  assign ent_key   = rd_data[KEY_BITS-1:0];
  assign ent_node  = rd_data[KEY_BITS+31:KEY_BITS];
  assign ent_stamp = rd_data[KEY_BITS+63:KEY_BITS+32];
  assign ent_hash  = rd_data[KEY_BITS+95:KEY_BITS+64];
  assign ent_valid = rd_data[EW-1];

  assign item_entry = {1'b1, hash_r, stamp_r, node_r, key_r};

  assign key_eq = fold_case
                ? (slpht_pkg::key_fold(64'(ent_key)) == slpht_pkg::key_fold(64'(key_r)))
                : (ent_key == key_r);
  assign empty = !ent_valid;
  assign match = ent_valid && (ent_hash == hash_r) && key_eq;
  assign last  = (nvis_r == {AW{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slpht_pkg::ST_INIT;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nvis_r  <= nvis_nxt;
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    hash_r  <= hash_nxt;
    node_r  <= node_nxt;
    stamp_r <= stamp_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    nvis_nxt  = nvis_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    hash_nxt  = hash_r;
    node_nxt  = node_r;
    stamp_nxt = stamp_r;
    res_nxt   = res_r;
    ready     = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = item_entry;
    rd_addr   = idx_r;

    case (state_r)
      slpht_pkg::ST_INIT: begin
        // Sweep every slot empty after reset
        wr_en   = 1'b1;
        wr_data = '0;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == {AW{1'b1}}) begin
          state_nxt = slpht_pkg::ST_IDLE;
        end
      end

      slpht_pkg::ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          cmd_nxt   = cmd;
          key_nxt   = key;
          hash_nxt  = hash;
          node_nxt  = node;
          stamp_nxt = stamp;
          res_nxt   = '0;
          nvis_nxt  = '0;
          case (cmd)
            slpht_pkg::CMD_FIND, slpht_pkg::CMD_PUT: begin
              rd_addr   = hash[AW-1:0];
              idx_nxt   = hash[AW-1:0];
              state_nxt = slpht_pkg::ST_PROBE;
            end
            slpht_pkg::CMD_CLEAR: begin
              cnt_nxt   = '0;
              idx_nxt   = '0;
              state_nxt = slpht_pkg::ST_CLEAR;
            end
            default: begin
              state_nxt = slpht_pkg::ST_EMIT;
            end
          endcase
        end
      end

      slpht_pkg::ST_PROBE: begin
        if (empty || match || last) begin
          state_nxt = slpht_pkg::ST_EMIT;
          if (cmd_r == slpht_pkg::CMD_FIND) begin
            if (match) begin
              res_nxt.hit        = 1'b1;
              res_nxt.found_node = ent_node;
            end
          end else if (match) begin
            if (ent_stamp != stamp_r) begin
              wr_en              = 1'b1;
              res_nxt.put_action = slpht_pkg::ACT_REPLACED;
            end else begin
              res_nxt.put_action = slpht_pkg::ACT_KEPT;
            end
          end else if (empty) begin
            wr_en              = 1'b1;
            cnt_nxt            = cnt_r + CW'(1);
            res_nxt.put_action = slpht_pkg::ACT_INSERTED;
          end else begin
            res_nxt.put_action = slpht_pkg::ACT_FULL;
          end
        end else begin
          // Advance to the next slot, wrapping
          idx_nxt  = idx_r + AW'(1);
          rd_addr  = idx_r + AW'(1);
          nvis_nxt = nvis_r + AW'(1);
        end
      end

      slpht_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == {AW{1'b1}}) begin
          state_nxt = slpht_pkg::ST_EMIT;
        end
      end

      slpht_pkg::ST_EMIT: begin
        // Hold until the output register can take the word
        if (res_free) begin
          res_valid = 1'b1;
          state_nxt = slpht_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = slpht_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res           = res_r;
    res.load_high = (cnt_r >= LOAD_LIM);
  end

endmodule

>>> rtl/stamped_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stamped_linear_probe_hash_table: open-addressed hash table, linear probing
// Find, put and clear on a table of keyed slots, with stamped replacement,
// optional case folding of keys and a load flag at three quarters full.
// ----------------------------------------------------------------------------
//  Port group   Dir  Handshake                Word
//  in_*         in   in_tvalid / in_tready    tdata key/hash/node/stamp, tuser cmd
//  out_*        out  out_tvalid / out_tready  tdata hit/found_node/put_action/load
//  cfg_*        in   APB write, pready high   fold_case at byte address 0
//
// A find or put probes one slot a cycle through the registered read port of
// the slot memory; clear sweeps the valid marks of every slot. After reset
// a sweep of every slot runs with in_tready low. A stalled result sits in
// the output register while the next word is taken; the controller waits
// only if it finishes with that register still full.
// ----------------------------------------------------------------------------
module stamped_linear_probe_hash_table #(
  parameter int unsigned SLOTS    = 1024,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_tvalid,
  output logic                             in_tready,
  // key_word[63:0], key_hash[95:64], node_handle[127:96], sync_stamp[159:128]
  input  logic [159:0]                     in_tdata,
  // cmd[1:0]
  input  logic [1:0]                       in_tuser,

  output logic                             out_tvalid,
  input  logic                             out_tready,
  // hit[0], found_node[32:1], put_action[35:33], load_high[36], zero[39:37]
  output logic [39:0]                      out_tdata,

  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [slpht_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [slpht_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [slpht_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  localparam logic [63:0] KEY_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - KEY_BITS);

  logic            fold_case_r, fold_case_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [39:0]     out_data_r, out_data_nxt;
  logic            cfg_wr;
  logic            start;
  logic            ready;
  logic            res_free;
  logic            res_valid;
  slpht_pkg::res_t res;
  logic [63:0]     key_c;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                   && (cfg_paddr[2] == slpht_pkg::REG_FOLD_CASE);
  assign cfg_prdata = (cfg_paddr[2] == slpht_pkg::REG_FOLD_CASE)
                    ? {{(slpht_pkg::CFG_DATA_W-1){1'b0}}, fold_case_r} : '0;

  assign fold_case_nxt = cfg_wr ? cfg_pwdata[0] : fold_case_r;

  assign key_c     = slpht_pkg::key_canon(in_tdata[63:0] & KEY_MASK);
  assign start     = in_tvalid && ready;
  assign in_tready = ready;
  assign res_free  = !out_valid_r || out_tready;

  slpht_ctrl #(
    .SLOTS   (SLOTS),
    .KEY_BITS(KEY_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .ready    (ready),
    .cmd      (in_tuser),
    .key      (key_c[KEY_BITS-1:0]),
    .hash     (in_tdata[95:64]),
    .node     (in_tdata[127:96]),
    .stamp    (in_tdata[159:128]),
    .fold_case(fold_case_r),
    .res_free (res_free),
    .res_valid(res_valid),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, res.load_high, res.put_action, res.found_node, res.hit};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_case_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fold_case_r <= fold_case_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> tb/stamped_linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stamped_linear_probe_hash_table_tb: self-checking bench for the hash table
// Streams finds, puts and clears into the table and predicts each result
// word from a shadow copy of the slots. Every field of every result word is
// compared in order. Directed cases come first. Random traffic follows with
// both case-folding settings, varied idling and one long output stall.
// ----------------------------------------------------------------------------
module stamped_linear_probe_hash_table_tb;

  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned KEY_BITS    = 64;
  localparam int          QUIET_LIMIT = 20000;
  localparam int          POOL_SIZE   = 24;
  localparam int          RAND_OPS    = 140;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [slpht_pkg::CFG_ADDR_W-1:0] ADDR_FOLD_CASE =
    {slpht_pkg::REG_FOLD_CASE, 2'b00};

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [31:0] hash;
    logic [31:0] node;
    logic [31:0] stamp;
  } table_op_t;

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             in_tvalid   = 1'b0;
  logic                             in_tready;
  logic [159:0]                     in_tdata    = '0;
  logic [1:0]                       in_tuser    = '0;
  logic                             out_tvalid;
  logic                             out_tready  = 1'b0;
  logic [39:0]                      out_tdata;
  logic                             cfg_psel    = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite  = 1'b0;
  logic [slpht_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [slpht_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [slpht_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                             cfg_pready;

  // shadow of the table
  bit          fold_on = 1'b0;
  bit          tbl_valid [SLOTS];
  logic [31:0] tbl_hash  [SLOTS];
  logic [31:0] tbl_stamp [SLOTS];
  logic [63:0] tbl_key   [SLOTS];
  logic [31:0] tbl_node  [SLOTS];
  int unsigned n_entries = 0;

  table_op_t       op_q[$];
  slpht_pkg::res_t outcome_q[$];
  table_op_t       sent_op;
  table_op_t       next_op;
  slpht_pkg::res_t got;
  slpht_pkg::res_t want;

  int send_idle_pct  = 34;
  int recv_stall_pct = 68;
  int hold_len       = 0;
  int hold_count     = 0;
  int err_count      = 0;
  int words_seen     = 0;
  int quiet_cycles   = 0;

  always #4 clk = ~clk;

  stamped_linear_probe_hash_table #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  function automatic logic [63:0] lower_key(input logic [63:0] w);
    logic [7:0] c;
    for (int b = 0; b < 8; b++) begin
      c = w[8*b +: 8];
      if (c >= 8'h41 && c <= 8'h5A) begin
        w[8*b + 5] = 1'b1;
      end
    end
    return w;
  endfunction

  function automatic logic [63:0] text_key(input string s);
    logic [63:0] w;
    w = '0;
    for (int b = 0; b < s.len() && b < 8; b++) begin
      w[8*b +: 8] = s[b];
    end
    return w;
  endfunction

  // apply one word to the shadow table and return the result it must give
  function automatic slpht_pkg::res_t table_outcome(input table_op_t op);
    slpht_pkg::res_t r;
    logic [63:0]     k;
    logic [63:0]     keep;
    int unsigned     idx;
    bit              matched;
    bit              empty;
    r       = '0;
    keep    = '1;
    matched = 1'b0;
    empty   = 1'b0;
    // a zero byte ends the string: drop it and everything above
    for (int b = 7; b >= 0; b--) begin
      if (op.key[8*b +: 8] == 8'h00) begin
        keep = (64'd1 << (8*b)) - 64'd1;
      end
    end
    k   = op.key & keep;
    idx = op.hash & (SLOTS - 1);
    if (op.cmd == slpht_pkg::CMD_CLEAR) begin
      foreach (tbl_valid[i]) begin
        tbl_valid[i] = 1'b0;
      end
      n_entries = 0;
    end else if (op.cmd == slpht_pkg::CMD_FIND || op.cmd == slpht_pkg::CMD_PUT) begin
      for (int n = 0; n < SLOTS; n++) begin
        if (!tbl_valid[idx]) begin
          empty = 1'b1;
          break;
        end
        if (tbl_hash[idx] == op.hash &&
            (fold_on ? lower_key(tbl_key[idx]) == lower_key(k) : tbl_key[idx] == k)) begin
          matched = 1'b1;
          break;
        end
        idx = (idx + 1) % SLOTS;
      end
      if (op.cmd == slpht_pkg::CMD_FIND) begin
        if (matched) begin
          r.hit        = 1'b1;
          r.found_node = tbl_node[idx];
        end
      end else if (matched) begin
        if (tbl_stamp[idx] != op.stamp) begin
          tbl_key[idx]   = k;
          tbl_node[idx]  = op.node;
          tbl_stamp[idx] = op.stamp;
          r.put_action   = slpht_pkg::ACT_REPLACED;
        end else begin
          r.put_action = slpht_pkg::ACT_KEPT;
        end
      end else if (empty) begin
        tbl_valid[idx] = 1'b1;
        tbl_hash[idx]  = op.hash;
        tbl_stamp[idx] = op.stamp;
        tbl_key[idx]   = k;
        tbl_node[idx]  = op.node;
        n_entries      = n_entries + 1;
        r.put_action   = slpht_pkg::ACT_INSERTED;
      end else begin
        r.put_action = slpht_pkg::ACT_FULL;
      end
    end
    r.load_high = (n_entries * 4 >= SLOTS * 3);
    return r;
  endfunction

  task automatic add_op(input logic [1:0] cmd, input logic [63:0] key,
                        input logic [31:0] hash, input logic [31:0] node,
                        input logic [31:0] stamp);
    table_op_t op;
    op.cmd   = cmd;
    op.key   = key;
    op.hash  = hash;
    op.node  = node;
    op.stamp = stamp;
    op_q.push_back(op);
  endtask

  task automatic set_fold_case(input bit on);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_FOLD_CASE;
    cfg_pwdata  <= {31'h0, on};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    fold_on = on;
  endtask

  // hold until every queued word has gone in and every result has come back
  task automatic drain();
    do @(negedge clk); while (op_q.size() != 0 || in_tvalid || outcome_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // mostly finds and puts on a small pool of colliding keys, some noise
  task automatic add_random_ops(input int count);
    logic [63:0] pool_key  [POOL_SIZE];
    logic [31:0] pool_hash [POOL_SIZE];
    logic [63:0] key;
    logic [31:0] hash;
    logic [31:0] stamp;
    logic [9:0]  base;
    logic [9:0]  off;
    logic [7:0]  low;
    int          len;
    int          pick;
    int          roll;
    for (int i = 0; i < POOL_SIZE; i++) begin
      len = $urandom_range(1, 8);
      key = '0;
      for (int b = 0; b < 8; b++) begin
        if (b < len) begin
          key[8*b +: 8] = 8'(8'h61 + $urandom_range(0, 25));
          if ($urandom_range(0, 1) == 1) begin
            key[8*b + 5] = 1'b0;
          end
        end else if (b > len && $urandom_range(0, 3) == 0) begin
          // junk past the terminator
          key[8*b +: 8] = 8'($urandom_range(0, 255));
        end
      end
      // two short runs of home slots, one of them wrapping past the top
      base      = (i % 2 == 0) ? 10'h010 : 10'h3F8;
      off       = 10'($urandom_range(0, 11));
      hash      = $urandom();
      hash[9:0] = base + off;
      pool_key[i]  = key;
      pool_hash[i] = (i % 6 == 5) ? pool_hash[i-1] : hash;
    end
    for (int n = 0; n < count; n++) begin
      roll  = $urandom_range(0, 99);
      pick  = $urandom_range(0, POOL_SIZE - 1);
      key   = pool_key[pick];
      stamp = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) begin
        // swap the case of some letters
        for (int b = 0; b < 8; b++) begin
          low = key[8*b +: 8] | 8'h20;
          if (low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 1) == 1) begin
            key[8*b + 5] = ~key[8*b + 5];
          end
        end
      end
      if (roll < 45) begin
        add_op(slpht_pkg::CMD_PUT, key, pool_hash[pick], $urandom(), stamp);
      end else if (roll < 85) begin
        add_op(slpht_pkg::CMD_FIND, key, pool_hash[pick], $urandom(), $urandom());
      end else if (roll < 87) begin
        add_op(slpht_pkg::CMD_CLEAR, {$urandom(), $urandom()}, $urandom(), $urandom(),
               $urandom());
      end else if (roll < 90) begin
        add_op(CMD_UNUSED, {$urandom(), $urandom()}, $urandom(), $urandom(), $urandom());
      end else begin
        add_op($urandom_range(0, 1) == 1 ? slpht_pkg::CMD_PUT : slpht_pkg::CMD_FIND,
               {$urandom(), $urandom()}, $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  // input side: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        sent_op.cmd   = in_tuser;
        sent_op.key   = in_tdata[63:0];
        sent_op.hash  = in_tdata[95:64];
        sent_op.node  = in_tdata[127:96];
        sent_op.stamp = in_tdata[159:128];
        outcome_q.push_back(table_outcome(sent_op));
      end
      if (!in_tvalid || in_tready) begin
        if (op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_op = op_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {next_op.stamp, next_op.node, next_op.hash, next_op.key};
          in_tuser  <= next_op.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side: compare against the oldest prediction, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[36:0];
        if (outcome_q.size() == 0) begin
          if (err_count < 10) begin
            $display("result word %0d arrived with nothing predicted", words_seen);
          end
          err_count = err_count + 1;
        end else begin
          want = outcome_q.pop_front();
          if (got.hit != want.hit || got.found_node != want.found_node ||
              got.put_action != want.put_action || got.load_high != want.load_high) begin
            if (err_count < 10) begin
              $display("result word %0d: want hit %0d node %h action %0d load %0d",
                       words_seen, want.hit, want.found_node, want.put_action,
                       want.load_high);
              $display("result word %0d: got  hit %0d node %h action %0d load %0d",
                       words_seen, got.hit, got.found_node, got.put_action,
                       got.load_high);
            end
            err_count = err_count + 1;
          end
        end
        words_seen = words_seen + 1;
      end
      if (hold_count < hold_len) begin
        out_tready <= 1'b0;
        hold_count <= hold_count + 1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [31:0] h;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_fold_case(1'b0);
    h = 32'h1234_0040;
    add_op(slpht_pkg::CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF);
    add_op(slpht_pkg::CMD_PUT, text_key("Alpha"), h, 32'h0, 32'h0);
    add_op(slpht_pkg::CMD_FIND, text_key("Alpha"), h, 32'h0, 32'h0);
    add_op(slpht_pkg::CMD_FIND, text_key("alpha"), h, 32'h0, 32'h0);
    add_op(slpht_pkg::CMD_PUT, text_key("Alpha"), h, 32'hFFFF_FFFF, 32'h0);
    add_op(slpht_pkg::CMD_PUT, text_key("Alpha"), h, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(slpht_pkg::CMD_FIND, text_key("Alpha"), h, 32'h0, 32'h0);
    // same home slot, then same slot with another full hash
    add_op(slpht_pkg::CMD_PUT, text_key("Beta"), h, 32'h0000_BE7A, 32'h7);
    add_op(slpht_pkg::CMD_FIND, text_key("Beta"), h, 32'h0, 32'h0);
    add_op(slpht_pkg::CMD_PUT, text_key("Alpha"), h ^ 32'h8000_0000, 32'h0000_0A2A, 32'h7);
    add_op(slpht_pkg::CMD_FIND, text_key("Alpha"), h ^ 32'h8000_0000, 32'h0, 32'h0);
    // embedded terminator in the top slot, then a probe that wraps to slot 0
    add_op(slpht_pkg::CMD_PUT, 64'h0000_0064_6300_6261, 32'hFFFF_FFFF, 32'h0000_00AB,
           32'h1);
    add_op(slpht_pkg::CMD_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_03FF, 32'h0000_00FF,
           32'h1);
    add_op(slpht_pkg::CMD_FIND, text_key("ab"), 32'hFFFF_FFFF, 32'h0, 32'h0);
    add_op(slpht_pkg::CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_03FF, 32'h0, 32'h0);
    add_op(slpht_pkg::CMD_PUT, 64'h0, 32'h0, 32'h0000_5A5A, 32'h1);
    add_op(slpht_pkg::CMD_FIND, 64'h0, 32'h0, 32'h0, 32'h0);
    add_op(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(slpht_pkg::CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF);
    add_op(slpht_pkg::CMD_FIND, text_key("Alpha"), h, 32'h0, 32'h0);
    drain();

    set_fold_case(1'b1);
    add_op(slpht_pkg::CMD_PUT, text_key("MiXeD"), 32'h0BAD_0123, 32'h1111_1111, 32'h10);
    add_op(slpht_pkg::CMD_FIND, text_key("mixed"), 32'h0BAD_0123, 32'h0, 32'h0);
    add_op(slpht_pkg::CMD_PUT, text_key("MIXED"), 32'h0BAD_0123, 32'h2222_2222, 32'h11);
    add_op(slpht_pkg::CMD_PUT, text_key("mixed"), 32'h0BAD_0123, 32'h3333_3333, 32'h11);
    // characters just outside A-Z must not fold
    add_op(slpht_pkg::CMD_PUT, 64'h7B60, 32'h0000_0200, 32'h4444_4444, 32'h0);
    add_op(slpht_pkg::CMD_FIND, 64'h5B40, 32'h0000_0200, 32'h0, 32'h0);
    drain();

    set_fold_case(1'b0);
    add_random_ops(RAND_OPS);
    drain();

    send_idle_pct  = 68;
    recv_stall_pct = 34;
    set_fold_case(1'b1);
    add_random_ops(RAND_OPS);
    drain();

    // long output stall while the sender keeps offering, no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_fold_case(1'b0);
    add_random_ops(RAND_OPS);
    hold_len = 300;
    drain();

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/slpht_pkg.sv
rtl/slpht_mem.sv
rtl/slpht_ctrl.sv
rtl/stamped_linear_probe_hash_table.sv
tb/stamped_linear_probe_hash_table_tb.sv
